// ===== rtl/scpr_pkg.sv =====
// Shared constants and types for the second-chance page replacer.
// Used by the request queue, the replacement engine and the top level.
package scpr_pkg;

   localparam int FRAMES      = 4;
   localparam int PAGE_BITS   = 16;
   localparam int IDX_W       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FILL_W      = $clog2(FRAMES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Fixed widths of the request and response fields
   localparam int REQ_PAGE_W  = 16;
   localparam int SLOT_W      = 2;
   localparam int EV_PAGE_W   = 16;
   localparam int FAULT_W     = 32;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USED_W  = SLOT_W + 1 + EV_PAGE_W + FAULT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP
   } engine_state_type;

   // Head of the request queue as seen by the engine
   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
   } queue_head_type;

endpackage

// ===== rtl/scpr_queue.sv =====
// Front end: accepts page references from the request stream into a short queue.
// Depends on scpr_pkg for the queue depth and page width.
module scpr_queue
   import scpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output queue_head_type        head,
   input  logic                  pop
);

   logic [PAGE_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push;
   logic                 do_pop;

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.page  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Keep only the page bits that the replacer compares
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= PAGE_BITS'(req_tdata[REQ_PAGE_W-1:0]);
      end
   end

endmodule

// ===== rtl/scpr_engine.sv =====
// Back end: frame table, reference bits, clock hand and fault counter.
// Looks up one queued page, fills or sweeps on a fault, and drives the response register.
module scpr_engine
   import scpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   engine_state_type     state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [PAGE_BITS-1:0] frame_ff [FRAMES];
   logic [FRAMES-1:0]    ref_ff, ref_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [FAULT_W-1:0]   fault_ff, fault_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [EV_PAGE_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_W-1:0]   rsp_fault_ff, rsp_fault_in;

   logic                 out_free;
   logic                 emit;
   logic [FRAMES-1:0]    match;
   logic                 any_match;
   logic [IDX_W-1:0]     match_idx;
   logic [FAULT_W-1:0]   fault_inc;
   logic                 frame_we;
   logic [IDX_W-1:0]     frame_wa;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fault_inc = (fault_ff == '1) ? fault_ff : fault_ff + 1'b1;

   // Parallel compare over the filled frames; the lowest match wins
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < FRAMES; i++) begin
         match[i] = (FILL_W'(i) < fill_ff) && (frame_ff[i] == page_ff);
      end
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = IDX_W'(i);
         end
      end
   end
   assign any_match = |match;

   always_comb begin
      state_in        = state_ff;
      page_in         = page_ff;
      ref_in          = ref_ff;
      fill_in         = fill_ff;
      hand_in         = hand_ff;
      fault_in        = fault_ff;
      pop             = 1'b0;
      emit            = 1'b0;
      frame_we        = 1'b0;
      frame_wa        = hand_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_fault_in    = rsp_fault_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               page_in  = head.page;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (any_match) begin
               if (out_free) begin
                  emit              = 1'b1;
                  ref_in[match_idx] = 1'b1;
                  rsp_hit_in        = 1'b1;
                  rsp_slot_in       = SLOT_W'(match_idx);
                  rsp_ev_valid_in   = 1'b0;
                  rsp_ev_page_in    = '0;
                  rsp_fault_in      = fault_ff;
                  state_in          = ST_IDLE;
               end
            end else if (fill_ff != FILL_W'(FRAMES)) begin
               if (out_free) begin
                  emit                         = 1'b1;
                  frame_we                     = 1'b1;
                  frame_wa                     = IDX_W'(fill_ff);
                  ref_in[IDX_W'(fill_ff)]      = 1'b1;
                  fill_in                      = fill_ff + 1'b1;
                  fault_in                     = fault_inc;
                  rsp_hit_in                   = 1'b0;
                  rsp_slot_in                  = SLOT_W'(fill_ff);
                  rsp_ev_valid_in              = 1'b0;
                  rsp_ev_page_in               = '0;
                  rsp_fault_in                 = fault_inc;
                  state_in                     = ST_IDLE;
               end
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (ref_ff[hand_ff]) begin
               // Second chance: clear and advance
               ref_in[hand_ff] = 1'b0;
               hand_in = (hand_ff == IDX_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;
            end else if (out_free) begin
               emit            = 1'b1;
               frame_we        = 1'b1;
               frame_wa        = hand_ff;
               ref_in[hand_ff] = 1'b1;
               fault_in        = fault_inc;
               rsp_hit_in      = 1'b0;
               rsp_slot_in     = SLOT_W'(hand_ff);
               rsp_ev_valid_in = 1'b1;
               rsp_ev_page_in  = EV_PAGE_W'(frame_ff[hand_ff]);
               rsp_fault_in    = fault_inc;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_ff       <= '0;
         fill_ff      <= '0;
         hand_ff      <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         fill_ff      <= fill_in;
         hand_ff      <= hand_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_fault_ff    <= rsp_fault_in;
      if (frame_we) begin
         frame_ff[frame_wa] <= page_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                        rsp_fault_ff, rsp_ev_page_ff, rsp_ev_valid_ff, rsp_slot_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAMES))
      else $error("fill level beyond frame count");

   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (fill_ff == FILL_W'(FRAMES)))
      else $error("sweep started with empty frames");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_hit_in) |=> (fault_ff == $past(fault_ff)))
      else $error("fault counted on a hit");

   a_evict_sets_ref: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_ev_valid_in) |=> ref_ff[$past(hand_ff)])
      else $error("replaced frame left without reference bit");

endmodule

// ===== rtl/second_chance_page_replacer_top.sv =====
// A request is registered in the queue, popped by the engine in its idle state and looked up;
// a hit or a fill loads the response register. A fault with all frames full enters a sweep
// that clears each set reference bit it meets and advances the hand, then replaces the frame.
// A request is popped only after the last response is registered, which waits on rsp_tready.
// Reset (synchronous, active high) empties the queue, frames, reference bits, hand and count.
// Top level of the second-chance page replacer; depends on scpr_pkg, scpr_queue, scpr_engine.
module second_chance_page_replacer_top
   import scpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // page_number[15:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slot[1:0], evicted_valid[2],
                                              // evicted_page[18:3], fault_total[50:19]
   output logic                  rsp_tuser    // hit
);

   queue_head_type head;
   logic           pop;

   scpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   scpr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the second-chance page replacer: streams page requests,
// predicts every response and checks it field by field.
// Depends on scpr_pkg and second_chance_page_replacer_top.
module tb_top;
   import scpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 1030;
   localparam int DRAIN_CYCLES   = 4 * (FRAMES + 4);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 40;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic                 evicted_valid;
      logic [EV_PAGE_W-1:0] evicted_page;
      logic [FAULT_W-1:0]   fault_total;
   } page_outcome_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // page_number[15:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // slot[1:0], evicted_valid[2],
                                            // evicted_page[18:3], fault_total[50:19]
   logic                  rsp_tuser;        // hit

   // Replacement state mirrored by the predictor
   logic [PAGE_BITS-1:0] frame_page [FRAMES];
   bit                   ref_bit    [FRAMES];
   int                   fill_count = 0;
   int                   hand       = 0;
   logic [FAULT_W-1:0]   faults     = '0;

   logic [REQ_PAGE_W-1:0] page_stream [$];
   page_outcome_type      pending_outcomes [$];
   int                    total_requests    = 0;
   int                    accepted_requests = 0;
   int                    mismatch_count    = 0;

   int          burst_left  = 0;
   int          gap_left    = 0;
   rx_mode_type rx_mode     = RX_ALWAYS;
   int          rx_left     = 0;
   int          cycle_count = 0;
   int          idle_cycles = 0;

   second_chance_page_replacer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic page_outcome_type predict_reference(input logic [REQ_DATA_W-1:0] word);
      page_outcome_type     res;
      logic [PAGE_BITS-1:0] page;
      int                   idx;
      int                   guard;
      res  = '0;
      page = word[PAGE_BITS-1:0];
      idx  = 0;
      for (int i = 0; i < fill_count; i++) begin
         if (!res.hit && frame_page[i] == page) begin
            res.hit = 1'b1;
            idx     = i;
         end
      end
      if (res.hit) begin
         ref_bit[idx] = 1'b1;
      end else begin
         if (faults != '1) begin
            faults = faults + 1'b1;
         end
         if (fill_count < FRAMES) begin
            idx = fill_count;
            fill_count++;
         end else begin
            // sweep: clear set bits until a clear one turns up
            for (guard = 0; guard <= FRAMES && ref_bit[hand]; guard++) begin
               ref_bit[hand] = 1'b0;
               hand = (hand + 1) % FRAMES;
            end
            idx                = hand;
            res.evicted_valid  = 1'b1;
            res.evicted_page   = EV_PAGE_W'(frame_page[idx]);
         end
         frame_page[idx] = page;
         ref_bit[idx]    = 1'b1;
      end
      res.slot        = SLOT_W'(idx);
      res.fault_total = faults;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      end
   endfunction

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (page_stream.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= page_stream.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Response sink: switch between randomly chosen stall patterns
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_mode    <= RX_ALWAYS;
         rx_left    <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(3, 0));
            rx_left <= $urandom_range(200, 20);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_ALWAYS:   rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= ($urandom_range(1, 0) == 1);
            RX_SPARSE:   rsp_tready <= ($urandom_range(7, 0) == 0);
            RX_PERIODIC: rsp_tready <= ((cycle_count % 7) < 3);
            default:     rsp_tready <= 1'b1;
         endcase
      end
   end

   // Check responses first, then predict the request accepted at this edge
   always @(posedge clock) begin
      page_outcome_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: response with none expected, expected none, actual %0h",
                           $time, rsp_tdata);
               end
            end else begin
               want = pending_outcomes.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_tuser));
               check_field("slot", 32'(want.slot), 32'(rsp_tdata[1:0]));
               check_field("evicted_valid", 32'(want.evicted_valid), 32'(rsp_tdata[2]));
               check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_tdata[18:3]));
               check_field("fault_total", want.fault_total, rsp_tdata[50:19]);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_outcomes.push_back(predict_reference(req_tdata));
            accepted_requests++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [REQ_PAGE_W-1:0] work_set [8];
      int                    set_size;
      int                    run_len;
      int                    made;

      // fill, hit, full-turn sweep, partial sweeps, re-fault of evicted pages
      page_stream = '{16'h0000, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                      16'h5555, 16'hAAAA, 16'h7FFE, 16'h8001, 16'h1234,
                      16'h0000, 16'hAAAA, 16'h1234, 16'hFFFF, 16'h5555,
                      16'h0001, 16'h8000, 16'h0001, 16'hFFFE, 16'h0000};
      made = 0;
      while (made < RANDOM_ITEMS) begin
         set_size = $urandom_range(7, 2);
         for (int k = 0; k < set_size; k++) begin
            work_set[k] = ($urandom_range(3, 0) == 0) ? REQ_PAGE_W'(k)
                                                      : REQ_PAGE_W'($urandom);
         end
         run_len = $urandom_range(80, 20);
         for (int r = 0; r < run_len && made < RANDOM_ITEMS; r++) begin
            // mostly a small working set so hits and sweeps occur; some stray pages
            if ($urandom_range(9, 0) == 0) begin
               page_stream.push_back(REQ_PAGE_W'($urandom));
            end else begin
               page_stream.push_back(work_set[$urandom_range(set_size - 1, 0)]);
            end
            made++;
         end
      end
      total_requests = page_stream.size();

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests < total_requests) @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/scpr_pkg.sv
rtl/scpr_queue.sv
rtl/scpr_engine.sv
rtl/second_chance_page_replacer_top.sv
sim/tb_top.sv
